[rtl/core/bpa_pkg.sv]
// ----------------------------------------------------------------------------
// Bitmap page allocator package
// Shared constants, reset values, codes and state type of the allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bpa_pkg;

  localparam int unsigned PAGE_BYTES = 4096;
  localparam int unsigned MAX_PAGES  = 65536;
  localparam int unsigned WORD_BITS  = 64;

  localparam int unsigned ADDR_W  = 48;
  localparam int unsigned LIMIT_W = 17;
  localparam int unsigned NUM_W   = 17;
  localparam int unsigned ALIGN_W = 31;
  localparam int unsigned STAT_W  = 3;

  localparam logic [ADDR_W-1:0]  REGION_RST = 48'h10_0000;
  localparam logic [LIMIT_W-1:0] LIMIT_RST  = 17'd65536;
  localparam logic [ADDR_W-1:0]  RSV_LO_RST = 48'h0A_0000;
  localparam logic [ADDR_W-1:0]  RSV_HI_RST = 48'h0B_FFFF;

  typedef enum logic [1:0] {
    OP_ALLOC,
    OP_FREE,
    OP_QUERY,
    OP_NONE
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    STS_OK,
    STS_BAD_ALIGN,
    STS_NO_SPACE,
    STS_BAD_ADDR,
    STS_END_MAP,
    STS_DOUBLE_FREE
  } status_e;

  typedef enum logic [1:0] {
    REG_REGION,
    REG_LIMIT,
    REG_RSV_LO,
    REG_RSV_HI
  } reg_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV_GO,
    S_DIV_WAIT,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_RMW_RD,
    S_RMW_LD,
    S_RMW_BIT,
    S_RMW_WR,
    S_QRY_RD,
    S_QRY_CHK,
    S_DONE
  } state_e;

endpackage

`default_nettype wire

[rtl/core/bpa_mod.sv]
// ----------------------------------------------------------------------------
// Bitmap page allocator remainder unit
// Bit-serial restoring remainder of an address by the alignment, one bit a cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bpa_mod #(
  parameter int unsigned DW = 48,
  parameter int unsigned VW = 31
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [DW-1:0] dividend_i,
  input  wire logic [VW-1:0] divisor_i,
  output logic               done_o,
  output logic [VW-1:0]      rem_o
);

  localparam int unsigned CW = $clog2(DW + 1);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] sh_q, sh_d;
  logic [VW-1:0] r_q, r_d;
  logic [VW:0]   trial;

  always_comb begin
    trial  = {r_q, sh_q[DW-1]};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    sh_d   = sh_q;
    r_d    = r_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      sh_d   = dividend_i;
      r_d    = '0;
    end else if (busy_q) begin
      sh_d  = {sh_q[DW-2:0], 1'b0};
      cnt_d = cnt_q + CW'(1);
      if (trial >= {1'b0, divisor_i}) begin
        r_d = VW'(trial - {1'b0, divisor_i});
      end else begin
        r_d = trial[VW-1:0];
      end
      if (cnt_q == CW'(DW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q <= sh_d;
    r_q  <= r_d;
  end

  assign done_o = done_q;
  assign rem_o  = r_q;

endmodule

`default_nettype wire

[rtl/core/bitmap_page_allocator.sv]
// ----------------------------------------------------------------------------
// Bitmap page allocator
// First-fit page run allocator over a bitmap held in one synchronous memory.
// ----------------------------------------------------------------------------
// Requests arrive as words on the s_axis channel and each gives one result
// word on the m_axis channel. The configuration port writes the region base,
// page limit and reserved window; the user must write them only while the
// block is idle, as the block itself does not enforce it.
// After reset the block sweeps all 2**ceil(log2(MAX_PAGES/WORD_BITS)) bitmap
// memory words (1024 by default) to zero, one memory word a cycle;
// s_axis_tready stays low until the sweep ends.
// A free clears its pages by a read-modify-write of each memory word touched.
// An allocation examines one page a cycle from page 0, pausing for the memory
// read at every word boundary and, when an alignment is given, for a remainder
// calculation at the start (and again if the page address wraps); it then
// marks the run by a read-modify-write of each memory word. One request is in
// flight at a time. The result waits in an output register while m_axis_tready
// is low; the block may take the next request meanwhile but holds its result
// until the register is free.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_page_allocator #(
  parameter int unsigned PAGE_BYTES = bpa_pkg::PAGE_BYTES,
  parameter int unsigned MAX_PAGES  = bpa_pkg::MAX_PAGES,
  parameter int unsigned WORD_BITS  = bpa_pkg::WORD_BITS
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [1:0]   cfg_index_i,
  input  wire logic [47:0]  cfg_data_i,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // page_total[16:0], align_bytes[47:17], phys_addr[95:48]
  input  wire logic [95:0]  s_axis_tdata,
  // op[1:0]
  input  wire logic [1:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // status[2:0], run_addr[50:3], is_used[51], zero padding[55:52]
  output logic [55:0]       m_axis_tdata
);

  localparam int unsigned LPB   = $clog2(PAGE_BYTES);
  localparam int unsigned BW    = $clog2(WORD_BITS);
  localparam int unsigned PW    = $clog2(MAX_PAGES) + 1;
  localparam int unsigned WORDS = MAX_PAGES / WORD_BITS;
  localparam int unsigned IW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned DEPTH = 1 << IW;
  localparam int unsigned LW    = (PW > 17) ? PW : 17;
  localparam logic [31:0] PB32  = 32'(PAGE_BYTES);

  bpa_pkg::state_e state_q, state_d;

  logic [47:0] region_q, rsv_lo_q, rsv_hi_q;
  logic [16:0] limit_reg_q;

  logic [1:0]           op_q, op_d;
  logic [16:0]          num_q, num_d;
  logic [30:0]          align_q, align_d;
  logic [16:0]          left_q, left_d;
  logic [PW-1:0]        p_q, p_d;
  logic [PW-1:0]        first_q, first_d;
  logic [47:0]          addr_q, addr_d;
  logic [47:0]          first_addr_q, first_addr_d;
  logic [30:0]          rem_q, rem_d;
  logic [WORD_BITS-1:0] wbuf_q, wbuf_d;
  logic [IW-1:0]        widx_q, widx_d;
  logic                 fin_q, fin_d;
  logic [2:0]           status_q, status_d;
  logic [47:0]          run_q, run_d;
  logic                 used_q, used_d;
  logic [IW-1:0]        clr_q, clr_d;

  logic        ov_q, ov_d;
  logic [55:0] odata_q, odata_d;

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [WORD_BITS-1:0] rdata_q;
  logic                 mem_we, mem_re;
  logic [IW-1:0]        mem_widx;
  logic [WORD_BITS-1:0] mem_wdata;

  logic          div_start, div_done;
  logic [30:0]   div_rem;

  logic          in_acc;
  bpa_pkg::op_e  in_op;
  logic [16:0]   in_num;
  logic [30:0]   in_align;
  logic [47:0]   in_phys;

  logic [LW-1:0] lim_x;
  logic [PW-1:0] limit;
  logic          bad_align;
  logic          loc_ok;
  logic [47:0]   loc_diff, loc_pg;
  logic [PW-1:0] p_inc;
  logic [48:0]   addr_sum;
  logic          wrap;
  logic          scan_hit, scan_end, skip, pg_bit, rsv;
  logic          al_big;
  logic [31:0]   rem_sum;
  logic [30:0]   rem_nxt;
  logic          rmw_stop;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign in_op    = bpa_pkg::op_e'(s_axis_tuser);
  assign in_num   = s_axis_tdata[16:0];
  assign in_align = s_axis_tdata[47:17];
  assign in_phys  = s_axis_tdata[95:48];

  assign lim_x = LW'(limit_reg_q);
  assign limit = (lim_x > LW'(MAX_PAGES)) ? PW'(MAX_PAGES) : PW'(lim_x);

  assign bad_align = (in_align != '0)
                     && !(((in_align & (in_align - 31'd1)) == '0)
                          && ({1'b0, in_align} <= PB32))
                     && (in_align[LPB-1:0] != '0);

  assign loc_diff = in_phys - region_q;
  assign loc_pg   = loc_diff >> LPB;
  assign loc_ok   = (in_phys >= region_q) && (loc_pg < 48'(limit));

  assign p_inc    = p_q + PW'(1);
  assign addr_sum = {1'b0, addr_q} + 49'(PAGE_BYTES);
  assign wrap     = addr_sum[48];
  assign pg_bit   = rdata_q[p_q[BW-1:0]];
  assign rsv      = (addr_q >= rsv_lo_q) && (addr_q < rsv_hi_q);
  assign scan_hit = (left_q == num_q);
  assign scan_end = (p_q >= limit) || scan_hit;
  assign skip     = (left_q == '0) && (align_q != '0) && (rem_q != '0);
  assign al_big   = {1'b0, align_q} > PB32;
  assign rem_sum  = {1'b0, rem_q} + PB32;

  always_comb begin
    if (!al_big) begin
      rem_nxt = rem_q;
    end else if (rem_sum >= {1'b0, align_q}) begin
      rem_nxt = 31'(rem_sum - {1'b0, align_q});
    end else begin
      rem_nxt = rem_sum[30:0];
    end
  end

  assign rmw_stop = (left_q == '0)
                    || ((op_q == bpa_pkg::OP_FREE)
                        && ((p_q >= limit) || !wbuf_q[p_q[BW-1:0]]));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bpa_pkg::S_CLEAR: begin
        if (&clr_q) state_d = bpa_pkg::S_IDLE;
      end
      bpa_pkg::S_IDLE: begin
        if (in_acc) begin
          unique case (in_op)
            bpa_pkg::OP_ALLOC: begin
              if (bad_align || (in_num == '0)) state_d = bpa_pkg::S_DONE;
              else if (in_align != '0) state_d = bpa_pkg::S_DIV_GO;
              else state_d = bpa_pkg::S_SCAN_RD;
            end
            bpa_pkg::OP_FREE: begin
              state_d = loc_ok ? bpa_pkg::S_RMW_RD : bpa_pkg::S_DONE;
            end
            bpa_pkg::OP_QUERY: begin
              state_d = loc_ok ? bpa_pkg::S_QRY_RD : bpa_pkg::S_DONE;
            end
            default: state_d = bpa_pkg::S_DONE;
          endcase
        end
      end
      bpa_pkg::S_DIV_GO: state_d = bpa_pkg::S_DIV_WAIT;
      bpa_pkg::S_DIV_WAIT: begin
        if (div_done) state_d = bpa_pkg::S_SCAN_RD;
      end
      bpa_pkg::S_SCAN_RD: state_d = bpa_pkg::S_SCAN_CHK;
      bpa_pkg::S_SCAN_CHK: begin
        if (scan_end) begin
          state_d = scan_hit ? bpa_pkg::S_RMW_RD : bpa_pkg::S_DONE;
        end else if (wrap && (align_q != '0)) begin
          state_d = bpa_pkg::S_DIV_GO;
        end else if (p_inc[BW-1:0] == '0) begin
          state_d = bpa_pkg::S_SCAN_RD;
        end
      end
      bpa_pkg::S_RMW_RD: state_d = bpa_pkg::S_RMW_LD;
      bpa_pkg::S_RMW_LD: state_d = bpa_pkg::S_RMW_BIT;
      bpa_pkg::S_RMW_BIT: begin
        if (rmw_stop || (p_inc[BW-1:0] == '0)) state_d = bpa_pkg::S_RMW_WR;
      end
      bpa_pkg::S_RMW_WR: state_d = fin_q ? bpa_pkg::S_DONE : bpa_pkg::S_RMW_RD;
      bpa_pkg::S_QRY_RD: state_d = bpa_pkg::S_QRY_CHK;
      bpa_pkg::S_QRY_CHK: state_d = bpa_pkg::S_DONE;
      bpa_pkg::S_DONE: begin
        if (!ov_q || m_axis_tready) state_d = bpa_pkg::S_IDLE;
      end
      default: state_d = bpa_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    op_d         = op_q;
    num_d        = num_q;
    align_d      = align_q;
    left_d       = left_q;
    p_d          = p_q;
    first_d      = first_q;
    addr_d       = addr_q;
    first_addr_d = first_addr_q;
    rem_d        = rem_q;
    wbuf_d       = wbuf_q;
    widx_d       = widx_q;
    fin_d        = fin_q;
    status_d     = status_q;
    run_d        = run_q;
    used_d       = used_q;
    clr_d        = clr_q;
    ov_d         = ov_q && !m_axis_tready;
    odata_d      = odata_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    div_start    = 1'b0;
    unique case (state_q)
      bpa_pkg::S_CLEAR: begin
        mem_we = 1'b1;
        clr_d  = clr_q + IW'(1);
      end
      bpa_pkg::S_IDLE: begin
        if (in_acc) begin
          op_d     = in_op;
          num_d    = in_num;
          align_d  = in_align;
          status_d = bpa_pkg::STS_OK;
          run_d    = '0;
          used_d   = 1'b0;
          fin_d    = 1'b0;
          addr_d   = region_q;
          p_d      = '0;
          left_d   = '0;
          rem_d    = '0;
          unique case (in_op)
            bpa_pkg::OP_ALLOC: begin
              if (bad_align) status_d = bpa_pkg::STS_BAD_ALIGN;
            end
            bpa_pkg::OP_FREE: begin
              if (!loc_ok) begin
                status_d = bpa_pkg::STS_BAD_ADDR;
              end else begin
                p_d    = loc_pg[PW-1:0];
                left_d = in_num;
              end
            end
            bpa_pkg::OP_QUERY: begin
              if (!loc_ok) status_d = bpa_pkg::STS_BAD_ADDR;
              else p_d = loc_pg[PW-1:0];
            end
            default: ;
          endcase
        end
      end
      bpa_pkg::S_DIV_GO: div_start = 1'b1;
      bpa_pkg::S_DIV_WAIT: begin
        if (div_done) rem_d = div_rem;
      end
      bpa_pkg::S_SCAN_RD: mem_re = 1'b1;
      bpa_pkg::S_SCAN_CHK: begin
        if (scan_end) begin
          if (scan_hit) begin
            p_d    = first_q;
            left_d = num_q;
            run_d  = first_addr_q;
          end else begin
            status_d = bpa_pkg::STS_NO_SPACE;
          end
        end else begin
          if (left_q == '0) begin
            first_d      = p_q;
            first_addr_d = addr_q;
          end
          if (!skip) left_d = (pg_bit || rsv) ? '0 : left_q + 17'd1;
          p_d    = p_inc;
          addr_d = addr_sum[47:0];
          rem_d  = rem_nxt;
        end
      end
      bpa_pkg::S_RMW_RD: mem_re = 1'b1;
      bpa_pkg::S_RMW_LD: begin
        wbuf_d = rdata_q;
        widx_d = p_q[BW +: IW];
      end
      bpa_pkg::S_RMW_BIT: begin
        if (rmw_stop) begin
          fin_d = 1'b1;
          if (left_q != '0) begin
            status_d = (p_q >= limit) ? bpa_pkg::STS_END_MAP : bpa_pkg::STS_DOUBLE_FREE;
          end
        end else begin
          wbuf_d[p_q[BW-1:0]] = (op_q == bpa_pkg::OP_ALLOC);
          p_d    = p_inc;
          left_d = left_q - 17'd1;
        end
      end
      bpa_pkg::S_RMW_WR: mem_we = 1'b1;
      bpa_pkg::S_QRY_RD: mem_re = 1'b1;
      bpa_pkg::S_QRY_CHK: used_d = pg_bit;
      bpa_pkg::S_DONE: begin
        if (!ov_q || m_axis_tready) begin
          ov_d    = 1'b1;
          odata_d = {4'b0000, used_q, run_q, status_q};
        end
      end
      default: ;
    endcase
  end

  assign mem_widx  = (state_q == bpa_pkg::S_CLEAR) ? clr_q : widx_q;
  assign mem_wdata = (state_q == bpa_pkg::S_CLEAR) ? '0 : wbuf_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_widx] <= mem_wdata;
    if (mem_re) rdata_q <= mem[p_q[BW +: IW]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_q    <= bpa_pkg::REGION_RST;
      limit_reg_q <= bpa_pkg::LIMIT_RST;
      rsv_lo_q    <= bpa_pkg::RSV_LO_RST;
      rsv_hi_q    <= bpa_pkg::RSV_HI_RST;
    end else if (cfg_we_i) begin
      unique case (bpa_pkg::reg_e'(cfg_index_i))
        bpa_pkg::REG_REGION: region_q    <= cfg_data_i;
        bpa_pkg::REG_LIMIT:  limit_reg_q <= cfg_data_i[16:0];
        bpa_pkg::REG_RSV_LO: rsv_lo_q    <= cfg_data_i;
        bpa_pkg::REG_RSV_HI: rsv_hi_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bpa_pkg::S_CLEAR;
      clr_q   <= '0;
      ov_q    <= 1'b0;
      fin_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      ov_q    <= ov_d;
      fin_q   <= fin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    num_q        <= num_d;
    align_q      <= align_d;
    left_q       <= left_d;
    p_q          <= p_d;
    first_q      <= first_d;
    addr_q       <= addr_d;
    first_addr_q <= first_addr_d;
    rem_q        <= rem_d;
    wbuf_q       <= wbuf_d;
    widx_q       <= widx_d;
    status_q     <= status_d;
    run_q        <= run_d;
    used_q       <= used_d;
    odata_q      <= odata_d;
  end

  bpa_mod #(
    .DW (48),
    .VW (31)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (addr_q),
    .divisor_i  (align_q),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  assign s_axis_tready = (state_q == bpa_pkg::S_IDLE);
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = odata_q;

endmodule

`default_nettype wire
